FILE: rtl/srs_pkg.sv
package srs_pkg;
    localparam int WINDOW_DEF    = 6;
    localparam int SEQ_SPACE_DEF = 12;
    localparam int SEQ_W         = 4;
    localparam int MSG_BYTES     = 20;

    localparam logic [1:0] MODE_MSG   = 2'd0;
    localparam logic [1:0] MODE_ACK   = 2'd1;
    localparam logic [1:0] MODE_TIMER = 2'd2;

    localparam logic [1:0] TMR_NONE    = 2'd0;
    localparam logic [1:0] TMR_START   = 2'd1;
    localparam logic [1:0] TMR_STOP    = 2'd2;
    localparam logic [1:0] TMR_RESTART = 2'd3;

    localparam logic [2:0] ST_SENT      = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_CORRUPT   = 3'd2;
    localparam logic [2:0] ST_ACK_EMPTY = 3'd3;
    localparam logic [2:0] ST_IGNORED   = 3'd4;
    localparam logic [2:0] ST_NEW_ACK   = 3'd5;
    localparam logic [2:0] ST_RESENT    = 3'd6;
    localparam logic [2:0] ST_NOTHING   = 3'd7;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item, clear sum
        logic sum_step;  // add one payload byte
        logic scan_clr;  // reset scan index to head
        logic scan_step; // advance scan index
        logic push;      // write new packet at tail
        logic mark;      // set acked flag of scanned packet
        logic pop;       // drop head packet
        logic emit_new;  // result: freshly pushed packet
        logic emit_scan; // result: packet at scan index
        logic emit_none; // result: no packet
        logic [1:0] timer;
        logic [2:0] status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] mode;
        logic sum_done;
        logic full;
        logic empty;
        logic cks_ok;
        logic in_win;
        logic scan_end;
        logic scan_match;
        logic scan_acked;
        logic scan_is_head;
        logic head_acked;
        logic one_left;
    } t_sts;
endpackage

FILE: rtl/srs_datapath.sv
module srs_datapath #(
    parameter int WINDOW = srs_pkg::WINDOW_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srs_pkg::t_cmd       i_cmd,
    output srs_pkg::t_sts       o_sts,
    input  logic [1:0]          i_mode,
    input  logic signed [31:0]  i_ack_seq_field,
    input  logic signed [31:0]  i_ack_number,
    input  logic signed [31:0]  i_ack_checksum,
    input  logic [63:0]         i_payload_low,
    input  logic [63:0]         i_payload_mid,
    input  logic [31:0]         i_payload_high,
    output logic [srs_pkg::SEQ_W-1:0] o_send_seq,
    output logic                o_send_valid,
    output logic signed [31:0]  o_send_checksum,
    output logic [63:0]         o_send_payload_low,
    output logic [63:0]         o_send_payload_mid,
    output logic [31:0]         o_send_payload_high,
    output logic [1:0]          o_timer_action,
    output logic [2:0]          o_status
);
    localparam int SEQ_SPACE = srs_pkg::SEQ_SPACE_DEF;
    localparam int SW = srs_pkg::SEQ_W;
    localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);
    localparam int AW = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
    localparam int BW = $clog2(srs_pkg::MSG_BYTES + 1);

    logic [SW-1:0] r_slot_seq [WINDOW];
    logic [31:0]   r_slot_cks [WINDOW];
    logic [63:0]   r_slot_lo  [WINDOW];
    logic [63:0]   r_slot_mid [WINDOW];
    logic [31:0]   r_slot_hi  [WINDOW];
    logic [SEQ_SPACE-1:0] r_acked;
    logic [PW-1:0] r_head, r_tail, r_scan;
    logic [CW-1:0] r_outst, r_scan_cnt;
    logic [SW-1:0] r_next_seq;

    logic [1:0]    r_mode;
    logic [31:0]   r_ack_seq, r_ack_num, r_ack_cks;
    logic [159:0]  r_pl;
    logic [31:0]   r_sum;
    logic [BW-1:0] r_byte;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] v);
        logic [PW-1:0] res;
        if ({{(32-PW){1'b0}}, v} == WINDOW - 1) res = '0;
        else res = v + 1'b1;
        return res;
    endfunction

    logic [7:0]  cur_byte;
    logic [31:0] ack_cks, new_cks;
    logic [AW-1:0] scan_idx, head_idx;
    logic signed [32:0] sf, sl, an;
    logic [SW-1:0] seq_inc;

    // sequence numbers stay below SEQ_SPACE, so they index the flags directly
    assign cur_byte = r_pl[{r_byte[BW-1:0], 3'b000} +: 8];
    assign ack_cks  = r_ack_seq + r_ack_num + r_sum;
    assign new_cks  = {{(32-SW){1'b0}}, r_next_seq} + 32'hFFFF_FFFF + r_sum;
    assign scan_idx = AW'(r_slot_seq[r_scan]);
    assign head_idx = AW'(r_slot_seq[r_head]);
    assign sf = $signed({{(33-SW){1'b0}}, r_slot_seq[r_head]});
    assign sl = $signed({{(33-SW){1'b0}}, r_slot_seq[r_tail]});
    assign an = $signed({r_ack_num[31], r_ack_num});
    assign seq_inc = ({{(32-SW){1'b0}}, r_next_seq} == SEQ_SPACE - 1) ? '0
                   : r_next_seq + 1'b1;

    always_comb begin
        o_sts.mode         = r_mode;
        o_sts.sum_done     = ({{(32-BW){1'b0}}, r_byte} == srs_pkg::MSG_BYTES);
        o_sts.full         = ({{(32-CW){1'b0}}, r_outst} >= WINDOW);
        o_sts.empty        = (r_outst == '0);
        o_sts.cks_ok       = (ack_cks == r_ack_cks);
        o_sts.in_win       = (sf <= sl) ? (an >= sf && an <= sl) : (an >= sf || an <= sl);
        o_sts.scan_end     = (r_scan_cnt == r_outst);
        o_sts.scan_match   = (an == $signed({{(33-SW){1'b0}}, r_slot_seq[r_scan]}));
        o_sts.scan_acked   = r_acked[scan_idx];
        o_sts.scan_is_head = (r_scan == r_head);
        o_sts.head_acked   = r_acked[head_idx];
        o_sts.one_left     = (r_outst == CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ack_seq <= i_ack_seq_field;
            r_ack_num <= i_ack_number;
            r_ack_cks <= i_ack_checksum;
            r_pl      <= {i_payload_high, i_payload_mid, i_payload_low};
            r_sum     <= '0;
        end else if (i_cmd.sum_step) begin
            r_sum <= r_sum + {{24{cur_byte[7]}}, cur_byte};
        end
        if (i_cmd.push) begin
            r_slot_seq[wrap_inc(r_tail)] <= r_next_seq;
            r_slot_cks[wrap_inc(r_tail)] <= new_cks;
            r_slot_lo[wrap_inc(r_tail)]  <= r_pl[63:0];
            r_slot_mid[wrap_inc(r_tail)] <= r_pl[127:64];
            r_slot_hi[wrap_inc(r_tail)]  <= r_pl[159:128];
        end
        if (i_cmd.emit_new) begin
            o_send_seq          <= r_next_seq;
            o_send_checksum     <= new_cks;
            o_send_payload_low  <= r_pl[63:0];
            o_send_payload_mid  <= r_pl[127:64];
            o_send_payload_high <= r_pl[159:128];
        end else if (i_cmd.emit_scan) begin
            o_send_seq          <= r_slot_seq[r_scan];
            o_send_checksum     <= r_slot_cks[r_scan];
            o_send_payload_low  <= r_slot_lo[r_scan];
            o_send_payload_mid  <= r_slot_mid[r_scan];
            o_send_payload_high <= r_slot_hi[r_scan];
        end else if (i_cmd.emit_none) begin
            o_send_seq          <= '0;
            o_send_checksum     <= '0;
            o_send_payload_low  <= '0;
            o_send_payload_mid  <= '0;
            o_send_payload_high <= '0;
        end
        if (i_cmd.emit_new || i_cmd.emit_scan || i_cmd.emit_none) begin
            o_timer_action <= i_cmd.timer;
            o_status       <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acked      <= '0;
            r_head       <= '0;
            r_tail       <= PW'(WINDOW - 1);
            r_outst      <= '0;
            r_next_seq   <= '0;
            r_scan       <= '0;
            r_scan_cnt   <= '0;
            r_byte       <= '0;
            r_mode       <= srs_pkg::MODE_MSG;
            o_send_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_mode <= i_mode;
                r_byte <= '0;
            end else if (i_cmd.sum_step) begin
                r_byte <= r_byte + 1'b1;
            end
            if (i_cmd.scan_clr) begin
                r_scan     <= r_head;
                r_scan_cnt <= '0;
            end else if (i_cmd.scan_step) begin
                r_scan     <= wrap_inc(r_scan);
                r_scan_cnt <= r_scan_cnt + 1'b1;
            end
            if (i_cmd.push) begin
                r_tail   <= wrap_inc(r_tail);
                r_outst  <= r_outst + 1'b1;
                r_acked[AW'(r_next_seq)] <= 1'b0;
                r_next_seq <= seq_inc;
            end
            if (i_cmd.mark) r_acked[scan_idx] <= 1'b1;
            if (i_cmd.pop) begin
                r_head  <= wrap_inc(r_head);
                r_outst <= r_outst - 1'b1;
            end
            if (i_cmd.emit_new || i_cmd.emit_scan) o_send_valid <= 1'b1;
            else if (i_cmd.emit_none) o_send_valid <= 1'b0;
        end
    end
endmodule

FILE: rtl/srs_ctrl.sv
module srs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  srs_pkg::t_sts i_sts,
    output srs_pkg::t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_DISP  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_SLIDE = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_valid, n_valid;
    logic       accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && i_stall;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                // hold the decision while the previous result is still waiting
                if (!i_sts.sum_done) o_cmd.sum_step = 1'b1;
                else if (!r_valid || !i_stall) n_state = S_DISP;
            end
            S_DISP: begin
                o_cmd.scan_clr = 1'b1;
                n_state = S_OUT;
                unique case (i_sts.mode)
                    srs_pkg::MODE_MSG: begin
                        if (i_sts.full) begin
                            o_cmd.emit_none = 1'b1;
                            o_cmd.status = srs_pkg::ST_FULL;
                        end else begin
                            o_cmd.push = 1'b1;
                            o_cmd.emit_new = 1'b1;
                            o_cmd.status = srs_pkg::ST_SENT;
                            o_cmd.timer = i_sts.empty ? srs_pkg::TMR_START
                                                      : srs_pkg::TMR_NONE;
                        end
                    end
                    srs_pkg::MODE_ACK: begin
                        if (!i_sts.cks_ok) begin
                            o_cmd.emit_none = 1'b1;
                            o_cmd.status = srs_pkg::ST_CORRUPT;
                        end else if (i_sts.empty) begin
                            o_cmd.emit_none = 1'b1;
                            o_cmd.status = srs_pkg::ST_ACK_EMPTY;
                        end else if (!i_sts.in_win) begin
                            o_cmd.emit_none = 1'b1;
                            o_cmd.status = srs_pkg::ST_IGNORED;
                        end else n_state = S_SCAN;
                    end
                    srs_pkg::MODE_TIMER: begin
                        if (i_sts.empty) begin
                            o_cmd.emit_none = 1'b1;
                            o_cmd.status = srs_pkg::ST_NOTHING;
                        end else n_state = S_SCAN;
                    end
                    default: begin
                        o_cmd.emit_none = 1'b1;
                        o_cmd.status = srs_pkg::ST_IGNORED;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    o_cmd.emit_none = 1'b1;
                    n_state = S_OUT;
                    if (i_sts.mode == srs_pkg::MODE_ACK) begin
                        o_cmd.status = srs_pkg::ST_IGNORED;
                    end else begin
                        o_cmd.status = srs_pkg::ST_NOTHING;
                        o_cmd.timer = srs_pkg::TMR_START;
                    end
                end else if (i_sts.mode == srs_pkg::MODE_ACK) begin
                    if (i_sts.scan_match && !i_sts.scan_acked) begin
                        o_cmd.mark = 1'b1;
                        if (i_sts.scan_is_head) n_state = S_SLIDE;
                        else begin
                            o_cmd.emit_none = 1'b1;
                            o_cmd.status = srs_pkg::ST_NEW_ACK;
                            n_state = S_OUT;
                        end
                    end else o_cmd.scan_step = 1'b1;
                end else begin
                    if (!i_sts.scan_acked) begin
                        o_cmd.emit_scan = 1'b1;
                        o_cmd.status = srs_pkg::ST_RESENT;
                        o_cmd.timer = srs_pkg::TMR_START;
                        n_state = S_OUT;
                    end else o_cmd.scan_step = 1'b1;
                end
            end
            S_SLIDE: begin
                if (!i_sts.empty && i_sts.head_acked) begin
                    o_cmd.pop = 1'b1;
                    if (i_sts.one_left) begin
                        o_cmd.emit_none = 1'b1;
                        o_cmd.status = srs_pkg::ST_NEW_ACK;
                        o_cmd.timer = srs_pkg::TMR_STOP;
                        n_state = S_OUT;
                    end
                end else begin
                    o_cmd.emit_none = 1'b1;
                    o_cmd.status = srs_pkg::ST_NEW_ACK;
                    o_cmd.timer = i_sts.empty ? srs_pkg::TMR_STOP
                                              : srs_pkg::TMR_RESTART;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_valid || !i_stall) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end
endmodule

FILE: rtl/selective_repeat_sender.sv
// Selective Repeat ARQ sender. Each input item is one event (mode): a message to send, an
// arriving ACK, or a timer expiry; each gives exactly one result item carrying the sent
// packet (if any), a timer command and a status code. Events are handled one at a time:
// the payload bytes are summed through one shared adder, a decision step follows, a scan of
// the window walks one slot per cycle and a slide pops one packet per cycle, and a final
// step raises the result. The next item can be accepted in the same cycle as the result
// becomes valid. The input is stalled from acceptance until the result is registered, and
// while an earlier result is still held the new item waits after its summation until the
// output side takes that result.
module selective_repeat_sender #(
    parameter int WINDOW = srs_pkg::WINDOW_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_ack_seq_field,
    input  logic signed [31:0] i_ack_number,
    input  logic signed [31:0] i_ack_checksum,
    input  logic [63:0]        i_payload_low,
    input  logic [63:0]        i_payload_mid,
    input  logic [31:0]        i_payload_high,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_send_valid,
    output logic [3:0]         o_send_seq,
    output logic signed [31:0] o_send_checksum,
    output logic [63:0]        o_send_payload_low,
    output logic [63:0]        o_send_payload_mid,
    output logic [31:0]        o_send_payload_high,
    output logic [1:0]         o_timer_action,
    output logic [2:0]         o_status
);
    srs_pkg::t_cmd cmd;
    srs_pkg::t_sts sts;

    srs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    srs_datapath #(.WINDOW(WINDOW)) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_mode              (i_mode),
        .i_ack_seq_field     (i_ack_seq_field),
        .i_ack_number        (i_ack_number),
        .i_ack_checksum      (i_ack_checksum),
        .i_payload_low       (i_payload_low),
        .i_payload_mid       (i_payload_mid),
        .i_payload_high      (i_payload_high),
        .o_send_seq          (o_send_seq),
        .o_send_valid        (o_send_valid),
        .o_send_checksum     (o_send_checksum),
        .o_send_payload_low  (o_send_payload_low),
        .o_send_payload_mid  (o_send_payload_mid),
        .o_send_payload_high (o_send_payload_high),
        .o_timer_action      (o_timer_action),
        .o_status            (o_status)
    );
endmodule

FILE: rtl/srs_checker.sv
module srs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_send_valid,
    input logic [3:0]  o_send_seq,
    input logic [1:0]  o_timer_action,
    input logic [2:0]  o_status
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_send_seq))
        else $error("result changed while stalled");

    a_send_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_send_valid == (o_status == srs_pkg::ST_SENT
                                     || o_status == srs_pkg::ST_RESENT))
        else $error("send_valid disagrees with status");

    a_no_pkt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_send_valid |-> o_send_seq == 4'd0)
        else $error("idle packet fields not zero");

    a_timer_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == srs_pkg::ST_FULL || o_status == srs_pkg::ST_CORRUPT
                    || o_status == srs_pkg::ST_ACK_EMPTY
                    || o_status == srs_pkg::ST_IGNORED)
        |-> o_timer_action == srs_pkg::TMR_NONE)
        else $error("timer command on rejected item");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted item did not block input");
endmodule

bind selective_repeat_sender srs_checker u_srs_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    localparam int WIN  = 6;
    localparam int SEQN = 12;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic        send_valid;
        logic [3:0]  send_seq;
        logic [31:0] send_checksum;
        logic [63:0] plo;
        logic [63:0] pmid;
        logic [31:0] phi;
        logic [1:0]  timer;
        logic [2:0]  status;
    } t_arq_result;

    class t_arq_scoreboard;
        logic [3:0]  slot_seq [WIN];
        logic [31:0] slot_cks [WIN];
        logic [63:0] slot_lo [WIN];
        logic [63:0] slot_mid [WIN];
        logic [31:0] slot_hi [WIN];
        bit          acked [SEQN];
        int          head, tail, outstanding, next_seq;
        t_arq_result pending [$];
        int          errors;

        function new();
            head = 0; tail = WIN - 1; outstanding = 0; next_seq = 0; errors = 0;
            foreach (acked[i]) acked[i] = 0;
        endfunction

        function logic [31:0] byte_sum(logic [63:0] lo, logic [63:0] mid, logic [31:0] hi);
            logic [159:0] all;
            logic [31:0]  s;
            all = {hi, mid, lo};
            s = 0;
            for (int i = 0; i < 20; i++) s += {{24{all[i*8+7]}}, all[i*8 +: 8]};
            return s;
        endfunction

        function void load_slot(ref t_arq_result r, input int k);
            r.send_valid = 1; r.send_seq = slot_seq[k]; r.send_checksum = slot_cks[k];
            r.plo = slot_lo[k]; r.pmid = slot_mid[k]; r.phi = slot_hi[k];
        endfunction

        function void note_event(logic [1:0] mode, logic [31:0] aseq, logic [31:0] anum,
                                 logic [31:0] acks, logic [63:0] lo, logic [63:0] mid,
                                 logic [31:0] hi);
            t_arq_result r;
            logic [31:0] cks;
            longint      an, sf, sl;
            bit          inwin, slide;
            r = '{default: 0};
            r.status = srs_pkg::ST_IGNORED;
            if (mode == srs_pkg::MODE_MSG) begin
                if (outstanding < WIN) begin
                    tail = (tail + 1) % WIN;
                    slot_seq[tail] = next_seq;
                    slot_cks[tail] = next_seq - 1 + byte_sum(lo, mid, hi);
                    slot_lo[tail] = lo; slot_mid[tail] = mid; slot_hi[tail] = hi;
                    outstanding++;
                    acked[next_seq] = 0;
                    load_slot(r, tail);
                    if (outstanding == 1) r.timer = srs_pkg::TMR_START;
                    next_seq = (next_seq + 1) % SEQN;
                    r.status = srs_pkg::ST_SENT;
                end else r.status = srs_pkg::ST_FULL;
            end else if (mode == srs_pkg::MODE_ACK) begin
                cks = aseq + anum + byte_sum(lo, mid, hi);
                an = $signed(anum);
                if (cks != acks) r.status = srs_pkg::ST_CORRUPT;
                else if (outstanding == 0) r.status = srs_pkg::ST_ACK_EMPTY;
                else begin
                    sf = slot_seq[head]; sl = slot_seq[tail];
                    inwin = (sf <= sl) ? (an >= sf && an <= sl) : (an >= sf || an <= sl);
                    slide = 0;
                    if (inwin) begin
                        for (int i = 0; i < outstanding; i++) begin
                            int k;
                            k = (head + i) % WIN;
                            if (slot_seq[k] == an && !acked[slot_seq[k]]) begin
                                acked[slot_seq[k]] = 1;
                                r.status = srs_pkg::ST_NEW_ACK;
                                slide = (k == head);
                                break;
                            end
                        end
                    end
                    if (slide) begin
                        while (outstanding > 0 && acked[slot_seq[head]]) begin
                            head = (head + 1) % WIN;
                            outstanding--;
                        end
                        r.timer = (outstanding > 0) ? srs_pkg::TMR_RESTART
                                                    : srs_pkg::TMR_STOP;
                    end
                end
            end else if (mode == srs_pkg::MODE_TIMER) begin
                r.status = srs_pkg::ST_NOTHING;
                for (int i = 0; i < outstanding; i++) begin
                    int k;
                    k = (head + i) % WIN;
                    if (!acked[slot_seq[k]]) begin
                        load_slot(r, k);
                        r.status = srs_pkg::ST_RESENT;
                        break;
                    end
                end
                if (outstanding > 0) r.timer = srs_pkg::TMR_START;
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_arq_result got);
            t_arq_result e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item st=%0d", got.status);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp v=%0d seq=%0d cks=%h lo=%h mid=%h hi=%h tm=%0d st=%0d",
                        e.send_valid, e.send_seq, e.send_checksum, e.plo, e.pmid, e.phi,
                        e.timer, e.status);
                    $display("         got v=%0d seq=%0d cks=%h lo=%h mid=%h hi=%h tm=%0d st=%0d",
                        got.send_valid, got.send_seq, got.send_checksum, got.plo, got.pmid,
                        got.phi, got.timer, got.status);
                end
            end
        endfunction
    endclass

    logic        i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0;
    logic        o_stall, o_valid;
    logic [1:0]  i_mode = 0;
    logic signed [31:0] i_ack_seq_field = 0, i_ack_number = 0, i_ack_checksum = 0;
    logic [63:0] i_payload_low = 0, i_payload_mid = 0;
    logic [31:0] i_payload_high = 0;
    logic        o_send_valid;
    logic [3:0]  o_send_seq;
    logic signed [31:0] o_send_checksum;
    logic [63:0] o_send_payload_low, o_send_payload_mid;
    logic [31:0] o_send_payload_high;
    logic [1:0]  o_timer_action;
    logic [2:0]  o_status;

    t_arq_scoreboard sb = new();
    bit          quiet_out = 0;

    selective_repeat_sender uut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{o_send_valid, o_send_seq, o_send_checksum, o_send_payload_low,
                              o_send_payload_mid, o_send_payload_high, o_timer_action,
                              o_status});
    end

    // result-side stall
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if (o_valid && !i_stall) begin
                gap = quiet_out ? 0 : $urandom_range(0, 16);
                if (gap > 0) begin
                    i_stall <= 1;
                    repeat (gap) @(negedge i_clk);
                    i_stall <= 0;
                end
            end
        end
    end

    task automatic send_event(logic [1:0] mode, logic [31:0] aseq, logic [31:0] anum,
                              logic [31:0] acks, logic [63:0] lo, logic [63:0] mid,
                              logic [31:0] hi, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1; i_mode <= mode; i_ack_seq_field <= aseq; i_ack_number <= anum;
        i_ack_checksum <= acks; i_payload_low <= lo; i_payload_mid <= mid;
        i_payload_high <= hi;
        do @(posedge i_clk); while (o_stall);
        sb.note_event(mode, aseq, anum, acks, lo, mid, hi);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_ack(logic [31:0] anum, bit good, bit no_gap);
        logic [31:0] aseq, cks;
        logic [63:0] lo, mid;
        logic [31:0] hi;
        aseq = ($urandom_range(0, 1)) ? $urandom() : 32'd0;
        lo = rnd64(); mid = rnd64(); hi = $urandom();
        cks = aseq + anum + sb.byte_sum(lo, mid, hi);
        if (!good) cks ^= 32'd1 << $urandom_range(0, 31);
        send_event(srs_pkg::MODE_ACK, aseq, anum, cks, lo, mid, hi, no_gap);
    endtask

    initial begin
        int pick, n;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // directed
        send_event(srs_pkg::MODE_TIMER, 0, 0, 0, 0, 0, 0, 0);
        send_ack(0, 1, 0);
        send_ack(0, 0, 0);
        send_event(srs_pkg::MODE_MSG, 0, 0, 0, '1, '1, '1, 1);
        send_event(srs_pkg::MODE_MSG, 0, 0, 0, 0, 0, 0, 1);
        send_event(srs_pkg::MODE_MSG, 0, 0, 0, 64'h8080808080808080, 64'h7f7f7f7f7f7f7f7f,
                   32'h80808080, 0);
        for (int i = 0; i < 4; i++)
            send_event(srs_pkg::MODE_MSG, '1, '1, '1, rnd64(), rnd64(), $urandom(), 1);
        send_ack(1, 1, 1);
        send_ack(1, 1, 0);
        send_ack(32'h80000000, 1, 0);
        send_ack(32'h7fffffff, 1, 0);
        send_ack(32'hffffffff, 1, 0);
        send_event(MODE_UNUSED, '1, '1, '1, '1, '1, '1, 0);
        send_event(srs_pkg::MODE_TIMER, 0, 0, 0, 0, 0, 0, 0);
        send_ack(0, 1, 0);
        send_ack(2, 1, 0);
        send_event(srs_pkg::MODE_TIMER, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 3; i < 6; i++) send_ack(i, 1, 1);
        send_event(srs_pkg::MODE_TIMER, 0, 0, 0, 0, 0, 0, 0);
        // random
        for (n = 0; n < 1350; n++) begin
            pick = $urandom_range(0, 99);
            quiet_out = (n / 200) % 3 == 2;
            if (pick < 40)
                send_event(srs_pkg::MODE_MSG, $urandom(), $urandom(), $urandom(), rnd64(),
                           rnd64(), $urandom(), quiet_out);
            else if (pick < 80)
                send_ack($urandom_range(0, 13) == 13 ? $urandom() : $urandom_range(0, 11),
                         $urandom_range(0, 9) != 0, quiet_out);
            else if (pick < 95)
                send_event(srs_pkg::MODE_TIMER, $urandom(), $urandom(), $urandom(), rnd64(),
                           rnd64(), $urandom(), quiet_out);
            else
                send_event(MODE_UNUSED, $urandom(), $urandom(), $urandom(), rnd64(), rnd64(),
                           $urandom(), quiet_out);
        end
        i_valid <= 0;
        n = 0;
        while (sb.pending.size() != 0 && n < 100000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
